// ----- hdl/boi_pkg.sv -----
// Shared widths, status codes and operation codes of the batch offset index.
`timescale 1ns / 1ps

package boi_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 1024;

	localparam int unsigned COUNT_W  = 17;
	localparam int unsigned POS_W    = 40;
	localparam int unsigned OFFSET_W = 63;
	localparam int unsigned STATUS_W = 2;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FIND   = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

endpackage

// ----- hdl/batch_offset_index.sv -----
// Batch offset index: an append-only table of record batches, each entry holding the
// first logical offset given to the batch and its file position, kept in one
// single-port-write, registered-read memory of MAX_ENTRIES words. An append word
// passes S_ADD, where the next offset range is summed, and S_APPEND, where it is
// checked and stored, before its result waits in S_RESULT. A find word passes
// S_CHECK and, if in range, S_SEARCH and S_CMP once per binary search step, then
// S_POS, since each step needs one memory read and one 63-bit compare, through the
// same read port and comparator. The block takes one word at a time and accepts
// the next word while the previous result still waits at the output.
`timescale 1ns / 1ps

module batch_offset_index #(
	parameter int unsigned MAX_ENTRIES = boi_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [boi_pkg::COUNT_W-1:0]   record_count,
	input  logic [boi_pkg::POS_W-1:0]     batch_position,
	input  logic [boi_pkg::OFFSET_W-1:0]  target_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [boi_pkg::OFFSET_W-1:0]  range_first,
	output logic [boi_pkg::OFFSET_W-1:0]  range_last,
	output logic [boi_pkg::POS_W-1:0]     found_position,
	output logic [boi_pkg::STATUS_W-1:0]  status
);

	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned IW = $clog2(MAX_ENTRIES);
	localparam int unsigned OW = boi_pkg::OFFSET_W;
	localparam int unsigned PW = boi_pkg::POS_W;
	localparam int unsigned MW = OW + PW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_APPEND,
		S_CHECK,
		S_SEARCH,
		S_CMP,
		S_POS,
		S_RESULT
	} state_t;

	state_t state_q;

	logic [boi_pkg::COUNT_W-1:0]  count_q;
	logic [PW-1:0]                pos_q;
	logic [OW-1:0]                target_q;

	logic [CW-1:0]                entry_count_q;
	logic [OW-1:0]                next_free_q;
	logic [OW:0]                  sum_q;

	logic [IW-1:0]                lo_q;
	logic [IW-1:0]                hi_q;
	logic [IW-1:0]                mid_q;

	logic [OW-1:0]                res_first_q;
	logic [OW-1:0]                res_last_q;
	logic [PW-1:0]                res_pos_q;
	logic [boi_pkg::STATUS_W-1:0] res_status_q;

	logic                         out_valid_q;
	logic [OW-1:0]                out_first_q;
	logic [OW-1:0]                out_last_q;
	logic [PW-1:0]                out_pos_q;
	logic [boi_pkg::STATUS_W-1:0] out_status_q;

	logic [MW-1:0]                mem [MAX_ENTRIES];
	logic [MW-1:0]                rd_q;
	logic [IW-1:0]                rd_addr;
	logic                         wr_en;
	logic [IW:0]                  span;
	logic [IW:0]                  mid_wide;
	logic [IW-1:0]                mid;
	logic [CW-1:0]                count_less_one;
	logic                         full;

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign range_first    = out_first_q;
	assign range_last     = out_last_q;
	assign found_position = out_pos_q;
	assign status         = out_status_q;

	assign full           = (entry_count_q == CW'(MAX_ENTRIES));
	assign count_less_one = entry_count_q - CW'(1);

	always_comb begin
		span     = {1'b0, hi_q} - {1'b0, lo_q} + (IW + 1)'(1);
		mid_wide = {1'b0, lo_q} + (span >> 1);
		mid      = mid_wide[IW-1:0];
		rd_addr  = (lo_q < hi_q) ? mid : lo_q;
		wr_en    = (state_q == S_APPEND) && !full && (count_q != '0) && !sum_q[OW];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[entry_count_q[IW-1:0]] <= {next_free_q, pos_q};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			pos_q         <= '0;
			target_q      <= '0;
			entry_count_q <= '0;
			next_free_q   <= '0;
			sum_q         <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			mid_q         <= '0;
			res_first_q   <= '0;
			res_last_q    <= '0;
			res_pos_q     <= '0;
			res_status_q  <= boi_pkg::STATUS_OK;
			out_valid_q   <= 1'b0;
			out_first_q   <= '0;
			out_last_q    <= '0;
			out_pos_q     <= '0;
			out_status_q  <= boi_pkg::STATUS_OK;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						count_q  <= record_count;
						pos_q    <= batch_position;
						target_q <= target_offset;
						state_q  <= (kind == boi_pkg::KIND_FIND) ? S_CHECK : S_ADD;
					end
				end
				S_ADD: begin
					sum_q   <= {1'b0, next_free_q} + (OW + 1)'(count_q);
					state_q <= S_APPEND;
				end
				S_APPEND: begin
					res_pos_q <= '0;
					priority if (full) begin
						res_status_q <= boi_pkg::STATUS_FULL;
						res_first_q  <= '0;
						res_last_q   <= '0;
					end else if (count_q == '0) begin
						res_status_q <= boi_pkg::STATUS_RANGE;
						res_first_q  <= '0;
						res_last_q   <= '0;
					end else if (sum_q[OW]) begin
						res_status_q <= boi_pkg::STATUS_OVERFLOW;
						res_first_q  <= '0;
						res_last_q   <= '0;
					end else begin
						res_status_q  <= boi_pkg::STATUS_OK;
						res_first_q   <= next_free_q;
						res_last_q    <= sum_q[OW-1:0] - OW'(1);
						next_free_q   <= sum_q[OW-1:0];
						entry_count_q <= entry_count_q + CW'(1);
					end
					state_q <= S_RESULT;
				end
				S_CHECK: begin
					res_first_q <= '0;
					res_last_q  <= '0;
					res_pos_q   <= '0;
					if ((entry_count_q == '0) || (target_q >= next_free_q)) begin
						res_status_q <= boi_pkg::STATUS_RANGE;
						state_q      <= S_RESULT;
					end else begin
						lo_q    <= '0;
						hi_q    <= count_less_one[IW-1:0];
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					mid_q   <= mid;
					state_q <= (lo_q < hi_q) ? S_CMP : S_POS;
				end
				S_CMP: begin
					if (rd_q[MW-1:PW] <= target_q) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - IW'(1);
					end
					state_q <= S_SEARCH;
				end
				S_POS: begin
					res_pos_q    <= rd_q[PW-1:0];
					res_status_q <= boi_pkg::STATUS_OK;
					state_q      <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_first_q  <= res_first_q;
						out_last_q   <= res_last_q;
						out_pos_q    <= res_pos_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The table never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	// An empty table has handed out no offsets, and a filled one has.
	assert property (@(posedge clk) disable iff (!arst_n)
		(entry_count_q == '0) == (next_free_q == '0))
		else $error("entry count and next free offset disagree");

	// The next free offset moves only when an entry is stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != $past(next_free_q)) |->
			(entry_count_q == $past(entry_count_q) + CW'(1)))
		else $error("next free offset moved without a stored entry");

	// The search window never inverts.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SEARCH) || (state_q == S_CMP)) |-> (lo_q <= hi_q))
		else $error("search window inverted");

	// A search never leaves the written part of the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> ({1'b0, hi_q} < (IW + 1)'(entry_count_q)))
		else $error("search beyond stored entries");

endmodule
